// ===== design/sbp_pkg.sv =====
// shared types and constants of the symbol bit packer
package sbp_pkg;

    // payload field widths
    localparam int SYM_VALUE_W = 16;
    localparam int SYM_IDX_W   = 4;
    localparam int SYM_LEN_W   = 5;
    localparam int MODE_W      = 3;
    localparam int WORD_W      = 16;
    localparam int CFG_W       = 5;

    // widest transmit word and the width of a bit position within it
    localparam int MAX_WORD_BITS = WORD_W;
    localparam int FP_W          = (MAX_WORD_BITS > 1) ? $clog2(MAX_WORD_BITS) : 1;

    // longest symbol taken from one item
    localparam int MAX_SYMBOL_BITS = 16;

    // word width after reset
    localparam logic [CFG_W-1:0] WORD_BITS_RST = CFG_W'(8);

    // stream position modes
    localparam logic [MODE_W-1:0] MODE_SINGLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIDDLE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LAST   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 3'd4;

    // operation of the shared bit unit
    typedef enum logic {
        UOP_INSERT,
        UOP_FILL
    } t_unit_op;

    // control bundle from the sequencer to the bit unit
    typedef struct packed {
        t_unit_op op;
        logic     bit_val;
    } t_unit_ctl;

endpackage

// ===== design/sbp_in_if.sv =====
// symbol input channel of the bit packer
interface sbp_in_if import sbp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [SYM_VALUE_W-1:0] symbol_value;
    logic [SYM_LEN_W-1:0]   symbol_length;
    logic [MODE_W-1:0]      mode;

    modport source (output valid, output symbol_value, output symbol_length,
                    output mode, input ready);
    modport sink   (input valid, input symbol_value, input symbol_length,
                    input mode, output ready);
endinterface

// ===== design/sbp_out_if.sv =====
// transmit word output channel of the bit packer
interface sbp_out_if import sbp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] tx_word;
    logic              last_of_run;

    modport source (output valid, output tx_word, output last_of_run, input ready);
    modport sink   (input valid, input tx_word, input last_of_run, output ready);
endinterface

// ===== design/sbp_bit_unit.sv =====
// shared bit unit: writes one bit or pads marks, and steps the fill position
module sbp_bit_unit import sbp_pkg::*; (
    input  logic [MAX_WORD_BITS-1:0] i_acc,
    input  logic [FP_W-1:0]          i_fp,
    input  logic [FP_W-1:0]          i_top,
    input  t_unit_ctl                i_ctl,
    output logic [MAX_WORD_BITS-1:0] o_acc,
    output logic [FP_W-1:0]          o_fp,
    output logic                     o_wrap
);

    // per bit: overwrite at the fill position, or set marks at and below it
    always_comb begin
        for (int k = 0; k < MAX_WORD_BITS; k++) begin
            if (i_ctl.op == UOP_FILL) begin
                o_acc[k] = i_acc[k] | (FP_W'(k) <= i_fp);
            end else begin
                o_acc[k] = (FP_W'(k) == i_fp) ? i_ctl.bit_val : i_acc[k];
            end
        end
    end

    // position steps down; a full word or a fill returns it to the top bit
    always_comb begin
        if (i_ctl.op == UOP_FILL) begin
            o_fp   = i_top;
            o_wrap = 1'b1;
        end else if (i_fp == '0) begin
            o_fp   = i_top;
            o_wrap = 1'b1;
        end else begin
            o_fp   = i_fp - FP_W'(1);
            o_wrap = 1'b0;
        end
    end

endmodule

// ===== design/symbol_bit_packer_with_mark_fill_unit.sv =====
// Symbol bit packer with mark fill. Each accepted item sends its symbol bits MSB first, one bit
// per clock unless a full word must wait for a stalled output, through a single shared bit unit,
// into a word of word_bits bits (i_cfg_wdata, reset 8); each full word is handed out with
// last_of_run set on the final word of the item. Single, last and flush items then pad a
// partial word with ones and emit it. i_sym.ready is high only between items. The output
// register lets the next item be taken while the last word waits.
module symbol_bit_packer_with_mark_fill_unit import sbp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    sbp_in_if.sink           i_sym,
    sbp_out_if.source        o_word
);

    localparam int RST_WB = (MAX_WORD_BITS < 8) ? MAX_WORD_BITS : 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FLUSH
    } t_state;

    t_state                   r_state, n_state;
    logic [CFG_W-1:0]         r_word_bits, n_word_bits;
    logic [MAX_WORD_BITS-1:0] r_acc, n_acc;
    logic [FP_W-1:0]          r_fp, n_fp;
    logic [FP_W-1:0]          r_top, n_top;
    logic [SYM_VALUE_W-1:0]   r_value, n_value;
    logic [SYM_LEN_W-1:0]     r_rem, n_rem;
    logic [MODE_W-1:0]        r_mode, n_mode;
    logic                     r_out_valid, n_out_valid;
    logic [WORD_W-1:0]        r_out_word, n_out_word;
    logic                     r_out_last, n_out_last;

    logic [CFG_W:0]           wb_eff;
    logic [FP_W-1:0]          cfg_top;
    logic [SYM_LEN_W-1:0]     len_eff;
    logic [SYM_LEN_W-1:0]     bit_idx;
    logic                     sym_bit;
    logic                     can_emit;
    logic                     pad_mode;
    t_unit_ctl                u_ctl;
    logic [MAX_WORD_BITS-1:0] u_acc;
    logic [FP_W-1:0]          u_fp;
    logic                     u_wrap;
    logic [MAX_WORD_BITS-1:0] masked;

    // effective word width and its top bit
    always_comb begin
        if (r_word_bits == '0) begin
            wb_eff = (CFG_W+1)'(1);
        end else if ({1'b0, r_word_bits} > (CFG_W+1)'(MAX_WORD_BITS)) begin
            wb_eff = (CFG_W+1)'(MAX_WORD_BITS);
        end else begin
            wb_eff = {1'b0, r_word_bits};
        end
        cfg_top = FP_W'(wb_eff - (CFG_W+1)'(1));
    end

    // clamp of the symbol length
    assign len_eff = ({1'b0, i_sym.symbol_length} > (SYM_LEN_W+1)'(MAX_SYMBOL_BITS))
                   ? SYM_LEN_W'(MAX_SYMBOL_BITS) : i_sym.symbol_length;

    // next symbol bit, MSB first; bits above the value field read as zero
    assign bit_idx = r_rem - SYM_LEN_W'(1);
    assign sym_bit = ({1'b0, bit_idx} < (SYM_LEN_W+1)'(SYM_VALUE_W))
                   ? r_value[bit_idx[SYM_IDX_W-1:0]] : 1'b0;

    assign can_emit = !r_out_valid || o_word.ready;
    assign pad_mode = (r_mode == MODE_SINGLE) || (r_mode == MODE_LAST) ||
                      (r_mode == MODE_FLUSH);

    // shared bit unit
    assign u_ctl.op      = (r_state == ST_FLUSH) ? UOP_FILL : UOP_INSERT;
    assign u_ctl.bit_val = sym_bit;

    sbp_bit_unit u_bit (
        .i_acc  (r_acc),
        .i_fp   (r_fp),
        .i_top  (r_top),
        .i_ctl  (u_ctl),
        .o_acc  (u_acc),
        .o_fp   (u_fp),
        .o_wrap (u_wrap)
    );

    // word as emitted: only the low word_bits bits
    always_comb begin
        for (int k = 0; k < MAX_WORD_BITS; k++) begin
            masked[k] = u_acc[k] & (FP_W'(k) <= r_top);
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_word_bits = i_cfg_we ? i_cfg_wdata : r_word_bits;
        n_acc       = r_acc;
        n_fp        = r_fp;
        n_top       = r_top;
        n_value     = r_value;
        n_rem       = r_rem;
        n_mode      = r_mode;
        n_out_valid = r_out_valid && !o_word.ready;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (i_sym.valid && (i_sym.mode <= MODE_FLUSH)) begin
                    n_top   = cfg_top;
                    n_fp    = ((r_fp > cfg_top) || (i_sym.mode == MODE_SINGLE) ||
                               (i_sym.mode == MODE_FIRST)) ? cfg_top : r_fp;
                    n_value = i_sym.symbol_value;
                    n_rem   = (i_sym.mode == MODE_FLUSH) ? '0 : len_eff;
                    n_mode  = i_sym.mode;
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (r_rem == '0) begin
                    n_state = (pad_mode && (r_fp != r_top)) ? ST_FLUSH : ST_IDLE;
                end else if (!u_wrap || can_emit) begin
                    n_acc = u_acc;
                    n_fp  = u_fp;
                    n_rem = r_rem - SYM_LEN_W'(1);
                    if (u_wrap) begin
                        n_out_valid = 1'b1;
                        n_out_word  = WORD_W'(masked);
                        // final word unless a later full word or a pad word follows
                        n_out_last  = (r_rem == SYM_LEN_W'(1)) ||
                                      (!pad_mode &&
                                       (r_rem <= (SYM_LEN_W'(r_top) + SYM_LEN_W'(1))));
                    end
                end
            end
            ST_FLUSH: begin
                if (can_emit) begin
                    n_acc       = u_acc;
                    n_fp        = u_fp;
                    n_out_valid = 1'b1;
                    n_out_word  = WORD_W'(masked);
                    n_out_last  = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_word_bits <= WORD_BITS_RST;
            r_acc       <= '1;
            r_fp        <= FP_W'(RST_WB - 1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word_bits <= n_word_bits;
            r_acc       <= n_acc;
            r_fp        <= n_fp;
            r_out_valid <= n_out_valid;
        end
        r_top      <= n_top;
        r_value    <= n_value;
        r_rem      <= n_rem;
        r_mode     <= n_mode;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    assign i_sym.ready        = (r_state == ST_IDLE);
    assign o_word.valid       = r_out_valid;
    assign o_word.tx_word     = r_out_word;
    assign o_word.last_of_run = r_out_last;

endmodule

// ===== design/sbp_checker.sv =====
// port-level checks of the symbol bit packer, bound to the top level
module sbp_checker import sbp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [MODE_W-1:0] i_in_mode,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [WORD_W-1:0] i_out_word,
    input logic              i_out_last
);

    // no word is offered right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("word offered after reset");

    // a valid item keeps the packer busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_mode <= MODE_FLUSH)) |=> !i_in_ready)
        else $error("packer ready right after a valid item");

    // an unknown mode is dropped and the packer stays ready
    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_in_mode > MODE_FLUSH)) |=> i_in_ready)
        else $error("unknown mode stalled the packer");

    // a stalled word stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("word dropped while stalled");

    // a stalled word keeps its payload
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_word) && $stable(i_out_last)))
        else $error("word changed while stalled");

endmodule

bind symbol_bit_packer_with_mark_fill_unit sbp_checker u_sbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sym.valid),
    .i_in_ready  (i_sym.ready),
    .i_in_mode   (i_sym.mode),
    .i_out_valid (o_word.valid),
    .i_out_ready (o_word.ready),
    .i_out_word  (o_word.tx_word),
    .i_out_last  (o_word.last_of_run)
);
